/* src/bnmc_pkg.sv */
// Shared types and constants for the box nesting chain cover block.
// Holds the payload structs, the datapath command and status structs and the op codes.
// No dependencies.
package bnmc_pkg;

  localparam int DIM_BITS = 16;
  localparam int OUT_BITS = 7;

  typedef struct packed {
    logic [DIM_BITS-1:0] dim_a;
    logic [DIM_BITS-1:0] dim_b;
    logic [DIM_BITS-1:0] dim_c;
    logic                last_box;
  } box_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] min_chains;
    logic                overflow;
  } chain_out_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_ROOT,
    OP_LOADV,
    OP_SCAN,
    OP_CHECK,
    OP_VCHK,
    OP_POPRD,
    OP_POPLD,
    OP_FLIPRD,
    OP_FLIPWR,
    OP_NEXTR,
    OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } dp_cmd_t;

  typedef struct packed {
    logic accept_last;
    logic clr_last;
    logic j_end;
    logic nests;
    logic mvalid;
    logic hit;
    logic depth_one;
    logic fidx_zero;
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage

/* src/box_nesting_min_chain_cover.sv */
// Top level of the box nesting chain cover block.
// Joins the controller bnmc_ctrl and the datapath bnmc_dp; depends on bnmc_pkg.
//
// Input channel (in_valid, in_stall, in_data): one box per transaction, three
// dimensions in any order plus last_box. Boxes load at one per cycle into the
// box store. A box that arrives with the store full is dropped and the set is
// flagged as overflowed.
// The transaction with last_box set starts the matching phase; in_stall then
// stays high until the result has been placed in the output register.
// The matching phase first clears the match and visit tables, one entry per box,
// then runs the augmenting path search: each root is set up, each candidate is
// read and checked (with a further visit check when the candidate is already
// matched), and the search pops its stack and flips the found path. It is bound
// by the single read port of the box store copy scanned for candidates.
// Output channel (out_valid, out_stall, out_data): one transaction per set,
// carrying min_chains and overflow. The output register frees the input side:
// loading of the next set may begin while the result waits on out_stall. A new
// result waits inside the block until the previous one has been taken.
// Reset (rst, synchronous) empties the set and drops any pending result.
module box_nesting_min_chain_cover #(
  parameter int MAX_BOXES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bnmc_pkg::box_in_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bnmc_pkg::chain_out_t out_data
);

  bnmc_pkg::dp_cmd_t    cmd;
  bnmc_pkg::dp_status_t status;

  bnmc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .status(status)
  );

  bnmc_dp #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk(clk),
    .rst(rst),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cmd(cmd),
    .status(status)
  );

endmodule

/* src/bnmc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bnmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/bnmc_ctrl.sv */
// Controller state machine for the box nesting chain cover block.
// Sequences loading, the matching search and the result; depends on bnmc_pkg.
module bnmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output bnmc_pkg::dp_cmd_t   cmd,
  input  bnmc_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_ROOT, S_LOADV, S_SCAN, S_CHECK, S_VCHK,
    S_POPRD, S_POPLD, S_FLIPRD, S_FLIPWR, S_NEXTR, S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (status.accept_last) state <= S_CLEAR;
        end
        S_CLEAR: begin
          if (status.clr_last) state <= S_ROOT;
        end
        S_ROOT:  state <= S_LOADV;
        S_LOADV: state <= S_SCAN;
        S_SCAN: begin
          if (!status.j_end) state <= S_CHECK;
          else if (status.depth_one) state <= S_NEXTR;
          else state <= S_POPRD;
        end
        S_CHECK: begin
          if (!status.nests) state <= S_SCAN;
          else if (status.mvalid) state <= S_VCHK;
          else if (status.depth_one) state <= S_NEXTR;
          else state <= S_FLIPRD;
        end
        S_VCHK: begin
          if (status.hit) state <= S_SCAN;
          else state <= S_LOADV;
        end
        S_POPRD:  state <= S_POPLD;
        S_POPLD:  state <= S_LOADV;
        S_FLIPRD: state <= S_FLIPWR;
        S_FLIPWR: begin
          if (status.fidx_zero) state <= S_NEXTR;
          else state <= S_FLIPRD;
        end
        S_NEXTR: begin
          if (status.root_last) state <= S_DONE;
          else state <= S_ROOT;
        end
        S_DONE: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.accept = (state == S_IDLE) && in_valid;
    case (state)
      S_IDLE:   cmd.op = bnmc_pkg::OP_IDLE;
      S_CLEAR:  cmd.op = bnmc_pkg::OP_CLEAR;
      S_ROOT:   cmd.op = bnmc_pkg::OP_ROOT;
      S_LOADV:  cmd.op = bnmc_pkg::OP_LOADV;
      S_SCAN:   cmd.op = bnmc_pkg::OP_SCAN;
      S_CHECK:  cmd.op = bnmc_pkg::OP_CHECK;
      S_VCHK:   cmd.op = bnmc_pkg::OP_VCHK;
      S_POPRD:  cmd.op = bnmc_pkg::OP_POPRD;
      S_POPLD:  cmd.op = bnmc_pkg::OP_POPLD;
      S_FLIPRD: cmd.op = bnmc_pkg::OP_FLIPRD;
      S_FLIPWR: cmd.op = bnmc_pkg::OP_FLIPWR;
      S_NEXTR:  cmd.op = bnmc_pkg::OP_NEXTR;
      S_DONE:   cmd.op = bnmc_pkg::OP_DONE;
      default:  cmd.op = bnmc_pkg::OP_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

/* src/bnmc_dp.sv */
// Datapath for the box nesting chain cover block: box store, matching tables,
// search stack, counters and the output register; depends on bnmc_pkg and bnmc_ram.
module bnmc_dp #(
  parameter int MAX_BOXES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bnmc_pkg::box_in_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bnmc_pkg::chain_out_t  out_data,
  input  bnmc_pkg::dp_cmd_t     cmd,
  output bnmc_pkg::dp_status_t  status
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int DB = bnmc_pkg::DIM_BITS;
  localparam int BW = 3 * DB;
  localparam int MW = 1 + IW;
  localparam int SW = IW + CW;

  logic [CW-1:0] count, cur_j, depth, matched;
  logic [IW-1:0] root, clr, fidx, cur_v;
  logic          dropped;
  logic [BW-1:0] cur_box;

  logic [DB-1:0] s_a0, s_b0, s_b1, s_c1, s_a2, s_b2;
  logic [BW-1:0] box_sorted;

  logic          box_we;
  logic [IW-1:0] boxa_raddr, vis_raddr, vis_waddr, match_waddr, stk_raddr;
  logic [BW-1:0] boxa_rd, boxb_rd;
  logic          match_we, vis_we, stk_we;
  logic [MW-1:0] match_wdata, match_rd;
  logic [CW-1:0] vis_wdata, vis_rd;
  logic [SW-1:0] stk_rd;
  logic [IW-1:0] partner, stk_box;
  logic [CW-1:0] stk_next, root_tag, diff;
  logic          nests, hit, out_free;

  always_comb begin
    s_a0 = in_data.dim_a;
    s_b0 = in_data.dim_b;
    if (in_data.dim_a < in_data.dim_b) begin
      s_a0 = in_data.dim_b;
      s_b0 = in_data.dim_a;
    end
    s_b1 = s_b0;
    s_c1 = in_data.dim_c;
    if (s_b0 < in_data.dim_c) begin
      s_b1 = in_data.dim_c;
      s_c1 = s_b0;
    end
    s_a2 = s_a0;
    s_b2 = s_b1;
    if (s_a0 < s_b1) begin
      s_a2 = s_b1;
      s_b2 = s_a0;
    end
    box_sorted = {s_a2, s_b2, s_c1};
  end

  assign partner  = match_rd[IW-1:0];
  assign stk_box  = stk_rd[SW-1:CW];
  assign stk_next = stk_rd[CW-1:0];
  assign root_tag = CW'(root) + CW'(1);
  assign nests    = (cur_box[BW-1:2*DB] < boxb_rd[BW-1:2*DB]) &&
                    (cur_box[2*DB-1:DB] < boxb_rd[2*DB-1:DB]) &&
                    (cur_box[DB-1:0] < boxb_rd[DB-1:0]);
  assign hit      = (vis_rd == root_tag) || (depth == CW'(MAX_BOXES));
  assign out_free = !out_valid || !out_stall;
  assign box_we   = cmd.accept && (count < CW'(MAX_BOXES));
  assign diff     = count - matched;

  always_comb begin
    boxa_raddr = root;
    if (cmd.op == bnmc_pkg::OP_VCHK) boxa_raddr = partner;
    if (cmd.op == bnmc_pkg::OP_POPLD) boxa_raddr = stk_box;
    stk_raddr = fidx;
    if (cmd.op == bnmc_pkg::OP_POPRD) stk_raddr = IW'(depth - CW'(2));
    vis_raddr = partner;

    match_we    = 1'b0;
    match_waddr = clr;
    match_wdata = '0;
    vis_we      = 1'b0;
    vis_waddr   = clr;
    vis_wdata   = '0;
    stk_we      = 1'b0;
    case (cmd.op)
      bnmc_pkg::OP_CLEAR: begin
        match_we = 1'b1;
        vis_we   = 1'b1;
      end
      bnmc_pkg::OP_ROOT: begin
        vis_we    = 1'b1;
        vis_waddr = root;
        vis_wdata = root_tag;
      end
      bnmc_pkg::OP_CHECK: begin
        if (nests && !match_rd[MW-1]) begin
          match_we    = 1'b1;
          match_waddr = cur_j[IW-1:0];
          match_wdata = {1'b1, cur_v};
        end
      end
      bnmc_pkg::OP_VCHK: begin
        if (!hit) begin
          vis_we    = 1'b1;
          vis_waddr = partner;
          vis_wdata = root_tag;
          stk_we    = 1'b1;
        end
      end
      bnmc_pkg::OP_FLIPWR: begin
        match_we    = 1'b1;
        match_waddr = IW'(stk_next - CW'(1));
        match_wdata = {1'b1, stk_box};
      end
      default: begin
      end
    endcase
  end

  bnmc_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_boxa (
    .clk(clk), .we(box_we), .waddr(count[IW-1:0]), .wdata(box_sorted),
    .raddr(boxa_raddr), .rdata(boxa_rd)
  );

  bnmc_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_boxb (
    .clk(clk), .we(box_we), .waddr(count[IW-1:0]), .wdata(box_sorted),
    .raddr(cur_j[IW-1:0]), .rdata(boxb_rd)
  );

  bnmc_ram #(.WIDTH(MW), .DEPTH(MAX_BOXES)) u_match (
    .clk(clk), .we(match_we), .waddr(match_waddr), .wdata(match_wdata),
    .raddr(cur_j[IW-1:0]), .rdata(match_rd)
  );

  bnmc_ram #(.WIDTH(CW), .DEPTH(MAX_BOXES)) u_visit (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rd)
  );

  bnmc_ram #(.WIDTH(SW), .DEPTH(MAX_BOXES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(IW'(depth - CW'(1))),
    .wdata({cur_v, cur_j + CW'(1)}),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      depth     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((cmd.op == bnmc_pkg::OP_DONE) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        bnmc_pkg::OP_IDLE: begin
          if (cmd.accept) begin
            if (box_we) count <= count + CW'(1);
            else dropped <= 1'b1;
            clr     <= '0;
            root    <= '0;
            matched <= '0;
          end
        end
        bnmc_pkg::OP_CLEAR: clr <= clr + IW'(1);
        bnmc_pkg::OP_ROOT: begin
          cur_v <= root;
          cur_j <= '0;
          depth <= CW'(1);
        end
        bnmc_pkg::OP_LOADV: cur_box <= boxa_rd;
        bnmc_pkg::OP_CHECK: begin
          if (!nests) begin
            cur_j <= cur_j + CW'(1);
          end else if (!match_rd[MW-1]) begin
            matched <= matched + CW'(1);
            fidx    <= IW'(depth - CW'(2));
          end
        end
        bnmc_pkg::OP_VCHK: begin
          if (hit) begin
            cur_j <= cur_j + CW'(1);
          end else begin
            cur_v <= partner;
            cur_j <= '0;
            depth <= depth + CW'(1);
          end
        end
        bnmc_pkg::OP_POPLD: begin
          cur_v <= stk_box;
          cur_j <= stk_next;
          depth <= depth - CW'(1);
        end
        bnmc_pkg::OP_FLIPWR: fidx <= fidx - IW'(1);
        bnmc_pkg::OP_NEXTR:  root <= root + IW'(1);
        bnmc_pkg::OP_DONE: begin
          if (out_free) begin
            out_data.min_chains <= bnmc_pkg::OUT_BITS'(diff);
            out_data.overflow   <= dropped;
            count               <= '0;
            dropped             <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status.accept_last = cmd.accept && in_data.last_box;
    status.clr_last    = (CW'(clr) + CW'(1)) == count;
    status.j_end       = (cur_j == count);
    status.nests       = nests;
    status.mvalid      = match_rd[MW-1];
    status.hit         = hit;
    status.depth_one   = (depth == CW'(1));
    status.fidx_zero   = (fidx == '0);
    status.root_last   = root_tag == count;
    status.out_free    = out_free;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (depth <= CW'(MAX_BOXES)) && (count <= CW'(MAX_BOXES)))
    else $error("search depth or box count beyond capacity");

  a_matched_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bnmc_pkg::OP_DONE) |-> (matched < count))
    else $error("matching larger than the box set");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bnmc_pkg::OP_DONE) && out_free |=> out_valid && (count == '0))
    else $error("result not loaded at the end of a set");

endmodule

/* test/box_nesting_min_chain_cover_tb.sv */
// Testbench for box_nesting_min_chain_cover: drives sets of boxes, predicts the
// fewest nesting chains with its own Kuhn matching model and checks each result.
// Depends on bnmc_pkg and the box_nesting_min_chain_cover RTL.
module box_nesting_min_chain_cover_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bnmc_pkg::box_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bnmc_pkg::chain_out_t out_data;

  bnmc_pkg::box_in_t box_queue[$];
  bnmc_pkg::chain_out_t chain_expected[$];
  int mismatch_count = 0;
  bit quiet_phase = 1'b0;
  bit long_hold = 1'b0;

  logic [15:0] set_big[CAP];
  logic [15:0] set_mid[CAP];
  logic [15:0] set_low[CAP];
  int set_size = 0;
  bit set_dropped = 1'b0;

  always #2 clk = ~clk;

  box_nesting_min_chain_cover #(.MAX_BOXES(CAP)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic bit fits_inside(int i, int j);
    return set_big[i] < set_big[j] && set_mid[i] < set_mid[j] && set_low[i] < set_low[j];
  endfunction

  function automatic int count_chains();
    int partner[CAP];
    bit taken[CAP];
    bit seen[CAP];
    int stk_box[CAP];
    int stk_next[CAP];
    int depth, top, v, j, w, matched;
    bit pushed, found;
    matched = 0;
    for (int k = 0; k < CAP; k++) begin
      taken[k] = 1'b0;
      partner[k] = 0;
    end
    for (int r = 0; r < set_size; r++) begin
      for (int k = 0; k < CAP; k++) seen[k] = 1'b0;
      seen[r] = 1'b1;
      stk_box[0] = r;
      stk_next[0] = 0;
      depth = 1;
      found = 1'b0;
      while (depth > 0 && !found) begin
        top = depth - 1;
        v = stk_box[top];
        j = stk_next[top];
        pushed = 1'b0;
        while (j < set_size && !pushed && !found) begin
          if (fits_inside(v, j)) begin
            if (!taken[j]) begin
              taken[j] = 1'b1;
              partner[j] = v;
              while (top > 0) begin
                top--;
                taken[stk_next[top] - 1] = 1'b1;
                partner[stk_next[top] - 1] = stk_box[top];
              end
              found = 1'b1;
            end else begin
              w = partner[j];
              if (!seen[w] && depth < CAP) begin
                seen[w] = 1'b1;
                stk_next[top] = j + 1;
                stk_box[depth] = w;
                stk_next[depth] = 0;
                depth++;
                pushed = 1'b1;
              end
            end
          end
          if (!pushed && !found) j++;
        end
        if (!pushed && !found) depth--;
      end
    end
    for (int k = 0; k < set_size; k++) if (taken[k]) matched++;
    return set_size - matched;
  endfunction

  function automatic void predict_box(bnmc_pkg::box_in_t b);
    logic [15:0] x, y, z, t;
    bnmc_pkg::chain_out_t res;
    x = b.dim_a;
    y = b.dim_b;
    z = b.dim_c;
    if (x < y) begin t = x; x = y; y = t; end
    if (y < z) begin t = y; y = z; z = t; end
    if (x < y) begin t = x; x = y; y = t; end
    if (set_size < CAP) begin
      set_big[set_size] = x;
      set_mid[set_size] = y;
      set_low[set_size] = z;
      set_size++;
    end else begin
      set_dropped = 1'b1;
    end
    if (b.last_box) begin
      res.min_chains = 7'(count_chains());
      res.overflow = set_dropped;
      chain_expected = {chain_expected, res};
      set_size = 0;
      set_dropped = 1'b0;
    end
  endfunction

  // Sender: a new item goes up at the falling edge after the previous one was taken, unless a random gap holds it back.
  int send_gap = 0;
  bit accepted = 1'b0;
  always @(posedge clk) accepted <= in_valid && !in_stall && !rst;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accepted) begin
      if (accepted) begin
        predict_box(in_data);
        if (!quiet_phase && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 18);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (box_queue.size() > 0) begin
        in_data <= box_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int hold_left = 0;
  always @(negedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
      hold_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (chain_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: chains %0d overflow %0b",
                   out_data.min_chains, out_data.overflow);
      end else begin
        if (out_data !== chain_expected[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected chains %0d overflow %0b, got chains %0d overflow %0b",
                     chain_expected[0].min_chains, chain_expected[0].overflow,
                     out_data.min_chains, out_data.overflow);
        end
        void'(chain_expected.pop_front());
      end
    end
  end

  function automatic bnmc_pkg::box_in_t make_box(bit last, int mode);
    bnmc_pkg::box_in_t b;
    int base;
    base = $urandom_range(0, 65535 - 64);
    case (mode)
      0: begin
        b.dim_a = 16'($urandom);
        b.dim_b = 16'($urandom);
        b.dim_c = 16'($urandom);
      end
      1: begin
        b.dim_a = 16'($urandom_range(0, 7));
        b.dim_b = 16'($urandom_range(0, 7));
        b.dim_c = 16'($urandom_range(0, 7));
      end
      default: begin
        b.dim_a = 16'(base + $urandom_range(0, 63));
        b.dim_b = 16'(base + $urandom_range(0, 63));
        b.dim_c = 16'(base + $urandom_range(0, 63));
      end
    endcase
    b.last_box = last;
    return b;
  endfunction

  function automatic void queue_box(bnmc_pkg::box_in_t b);
    box_queue = {box_queue, b};
  endfunction

  task automatic add_set(int sz, int mode);
    for (int k = 0; k < sz; k++) queue_box(make_box(k == sz - 1, mode));
  endtask

  function automatic bnmc_pkg::box_in_t dims(int a, int b, int c, bit last);
    bnmc_pkg::box_in_t x;
    x.dim_a = 16'(a);
    x.dim_b = 16'(b);
    x.dim_c = 16'(c);
    x.last_box = last;
    return x;
  endfunction

  initial begin
    int sent, sz, wait_cycles;
    queue_box(dims(0, 0, 0, 1'b1));
    queue_box(dims(65535, 65535, 65535, 1'b0));
    queue_box(dims(0, 0, 0, 1'b0));
    queue_box(dims(3, 1, 2, 1'b0));
    queue_box(dims(2, 4, 3, 1'b1));
    queue_box(dims(5, 5, 5, 1'b0));
    queue_box(dims(5, 5, 5, 1'b0));
    queue_box(dims(65535, 0, 32768, 1'b1));
    for (int k = 0; k < 70; k++) queue_box(dims(k, k + 1, k + 2, k == 69));
    add_set(CAP, 1);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    sent = 0;
    while (sent < 1700) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 66) : $urandom_range(1, 12);
      add_set(sz, $urandom_range(0, 2));
      sent += sz;
    end
    wait (box_queue.size() < 600);
    long_hold = 1'b1;
    repeat (3000) @(posedge clk);
    long_hold = 1'b0;
    wait (box_queue.size() < 150);
    quiet_phase = 1'b1;
    for (int k = 0; k < 20; k++) add_set($urandom_range(1, 8), $urandom_range(0, 2));
    wait (box_queue.size() == 0 && !in_valid);
    wait_cycles = 0;
    while (chain_expected.size() > 0 && wait_cycles < 2000000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && chain_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end
endmodule

/* sim.f */
src/bnmc_pkg.sv
src/bnmc_ram.sv
src/bnmc_ctrl.sv
src/bnmc_dp.sv
src/box_nesting_min_chain_cover.sv
test/box_nesting_min_chain_cover_tb.sv
